FILE: src/moving_average_stillness_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average stillness detector.
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_STILLNESS_DETECTOR_ASSERT_SVH
`define MOVING_AVERAGE_STILLNESS_DETECTOR_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define MSD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stillness detector: invariant violated");

// When the trigger holds, the consequence holds in the next cycle.
`define MSD_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("stillness detector: sequence violated");

`endif

FILE: src/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants of the moving-average stillness detector.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int unsigned THRESH_W        = 15;
  localparam int unsigned RESET_THRESHOLD = 256;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  typedef struct packed {
    logic valid;
    logic clear;
    logic filled;
  } win_stat_t;

endpackage

FILE: src/msd_front.sv
// ----------------------------------------------------------------------------
// msd_front
// Accepts input words, decodes the action and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module msd_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [SAMPLE_WIDTH-1:0] in_velocity_sample,
  output msd_pkg::q_head_t        head,
  output logic [SAMPLE_WIDTH-1:0] head_sample,
  input  logic                    pop
);
  import msd_pkg::*;

  op_t                     q_op_r     [2];
  logic [SAMPLE_WIDTH-1:0] q_sample_r [2];
  logic                    rd_ptr_r, rd_ptr_nxt;
  logic                    wr_ptr_r, wr_ptr_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    push;
  op_t                     dec_op;

  always_comb begin
    case (in_action)
      1'b1:    dec_op = OP_CLEAR;
      default: dec_op = OP_PUSH;
    endcase
  end

  assign in_ready     = (cnt_r != 2'd2);
  assign push         = in_valid && in_ready;
  assign head.valid   = (cnt_r != 2'd0);
  assign head.op      = q_op_r[rd_ptr_r];
  assign head_sample  = q_sample_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op_r[wr_ptr_r]     <= dec_op;
      q_sample_r[wr_ptr_r] <= in_velocity_sample;
    end
  end

endmodule

FILE: src/msd_window.sv
// ----------------------------------------------------------------------------
// msd_window
// Ring window memory with running sum; executes pushes and clears in order.
// ----------------------------------------------------------------------------
`include "moving_average_stillness_detector_assert.svh"

module msd_window #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned SUM_W        = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msd_pkg::q_head_t        head,
  input  logic [SAMPLE_WIDTH-1:0] head_sample,
  output logic                    pop,
  output msd_pkg::win_stat_t      stat,
  output logic signed [SUM_W-1:0] sum,
  input  logic                    take
);
  import msd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);

  logic [SAMPLE_WIDTH-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    filled_r, filled_nxt;
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_clear_r, s1_clear_nxt;
  logic                    do_push;
  logic signed [SAMPLE_WIDTH-1:0] old_s, new_s;

  assign pop     = head.valid && (!s1_valid_r || take);
  assign do_push = pop && (head.op == OP_PUSH);
  assign old_s   = filled_r ? $signed(rd_data_r) : '0;
  assign new_s   = $signed(head_sample);

  always_comb begin
    slot_nxt     = slot_r;
    sum_nxt      = sum_r;
    filled_nxt   = filled_r;
    s1_clear_nxt = s1_clear_r;
    s1_valid_nxt = take ? 1'b0 : s1_valid_r;
    if (pop) begin
      s1_valid_nxt = 1'b1;
      case (head.op)
        OP_CLEAR: begin
          slot_nxt     = '0;
          sum_nxt      = '0;
          filled_nxt   = 1'b0;
          s1_clear_nxt = 1'b1;
        end
        default: begin
          sum_nxt      = sum_r - SUM_W'(old_s) + SUM_W'(new_s);
          s1_clear_nxt = 1'b0;
          if (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) begin
            slot_nxt   = '0;
            filled_nxt = 1'b1;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      sum_r      <= '0;
      filled_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      slot_r     <= slot_nxt;
      sum_r      <= sum_nxt;
      filled_r   <= filled_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_clear_r <= s1_clear_nxt;
  end

  // The entry at the next slot is fetched into a register ahead of its use.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[slot_r] <= head_sample;
    end
    rd_data_r <= mem[slot_nxt];
  end

  assign stat.valid  = s1_valid_r;
  assign stat.clear  = s1_clear_r;
  assign stat.filled = filled_r;
  assign sum         = sum_r;

  `MSD_ASSERT_ALWAYS(a_slot_in_range, slot_r <= SLOT_W'(WINDOW_DEPTH - 1))
  `MSD_ASSERT_NEXT(a_clear_empties, pop && head.op == OP_CLEAR,
                   sum_r == '0 && !filled_r && slot_r == '0)
  `MSD_ASSERT_NEXT(a_fill_on_wrap, !filled_r && do_push && slot_r != SLOT_W'(WINDOW_DEPTH - 1),
                   !filled_r)
  `MSD_ASSERT_ALWAYS(a_take_needs_item, !take || s1_valid_r)

endmodule

FILE: src/msd_band.sv
// ----------------------------------------------------------------------------
// msd_band
// Band test of the window sum, stillness counter and the result register.
// ----------------------------------------------------------------------------
module msd_band #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SUM_W        = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msd_pkg::THRESH_W-1:0]     cfg_data,
  input  msd_pkg::win_stat_t               stat,
  input  logic signed [SUM_W-1:0]          sum,
  output logic                             take,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_on_ground,
  output logic                             out_window_ready
);
  import msd_pkg::*;

  localparam int unsigned LIM_W = THRESH_W + $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W = ((SUM_W > LIM_W + 1) ? SUM_W : LIM_W + 1) + 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

  logic [LIM_W-1:0]        limit_r, limit_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    og_r, og_nxt;
  logic                    wr_r, wr_nxt;
  logic signed [CMP_W-1:0] sum_ext, lim_ext;
  logic                    in_band;
  logic                    out_go;

  assign limit_nxt = cfg_we ? (LIM_W'(cfg_data) * LIM_W'(WINDOW_DEPTH)) : limit_r;
  assign sum_ext   = CMP_W'(sum);
  assign lim_ext   = CMP_W'($signed({1'b0, limit_r}));
  assign in_band   = (sum_ext < lim_ext) && (sum_ext > -lim_ext);
  assign out_go    = !out_valid_r || out_ready;
  assign take      = stat.valid && out_go;

  always_comb begin
    cnt_nxt       = cnt_r;
    og_nxt        = og_r;
    wr_nxt        = wr_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      wr_nxt        = stat.filled;
      og_nxt        = 1'b0;
      if (stat.clear) begin
        cnt_nxt = '0;
      end else if (stat.filled) begin
        if (!in_band) begin
          cnt_nxt = '0;
        end else if (cnt_r != CNT_W'(WINDOW_DEPTH)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        og_nxt = (cnt_nxt == CNT_W'(WINDOW_DEPTH));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIM_W'(RESET_THRESHOLD) * LIM_W'(WINDOW_DEPTH);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    og_r <= og_nxt;
    wr_r <= wr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_on_ground    = og_r;
  assign out_window_ready = wr_r;

endmodule

FILE: src/moving_average_stillness_detector.sv
// ----------------------------------------------------------------------------
// moving_average_stillness_detector
// An accepted word passes the FIFO, the window stage and the result register.
// Throughput: one word per cycle while out_ready is high, set by the
// running-sum update and the one-ahead read of the window memory.
// Reset: synchronous; empties the window and restores a threshold of 256.
// ----------------------------------------------------------------------------
module moving_average_stillness_detector #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic signed [SAMPLE_WIDTH-1:0] in_velocity_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_on_ground,
  output logic                         out_window_ready,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [msd_pkg::THRESH_W-1:0] cfg_band_threshold
);
  import msd_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);

  q_head_t                 head;
  logic [SAMPLE_WIDTH-1:0] head_sample;
  logic                    pop;
  win_stat_t               stat;
  logic signed [SUM_W-1:0] sum;
  logic                    take;
  logic                    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  msd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_velocity_sample (in_velocity_sample),
    .head               (head),
    .head_sample        (head_sample),
    .pop                (pop)
  );

  msd_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_W        (SUM_W)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_sample (head_sample),
    .pop         (pop),
    .stat        (stat),
    .sum         (sum),
    .take        (take)
  );

  msd_band #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_band (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_band_threshold),
    .stat             (stat),
    .sum              (sum),
    .take             (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_on_ground    (out_on_ground),
    .out_window_ready (out_window_ready)
  );

endmodule
